// ===== hdl/vgfp_pkg.sv =====
// ----------------------------------------------------------------------------
// vgfp_pkg: shared types and constants for the genotype field parser
// Input and result transfer structs, byte classes, parser phase and the
// characters the parser reacts to.
// ----------------------------------------------------------------------------
package vgfp_pkg;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       line_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] allele_first;
        logic [7:0] allele_second;
        logic       phased;
        logic       missing;
        logic       no_separator;
        logic       sample_last;
    } out_item_t;

    // One input byte after classification by the front end
    typedef struct packed {
        logic       line_end;
        logic       is_tab;
        logic       is_g;
        logic       is_t;
        logic       is_dot;
        logic       is_bar;
        logic       is_slash;
        logic       is_digit;
        logic [3:0] digit;
    } byte_class_t;

    typedef enum logic {
        PH_SEARCH,
        PH_FIELD
    } phase_t;

    typedef enum logic [1:0] {
        TAG_NONE,
        TAG_G,
        TAG_GT
    } tag_t;

    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_G     = 8'h47;
    localparam logic [7:0] CHAR_T     = 8'h54;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_BAR   = 8'h7C;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [7:0] ALLELE_MISSING = 8'hFF;

endpackage

// ===== hdl/vgfp_front.sv =====
// ----------------------------------------------------------------------------
// vgfp_front: input byte classifier
// Accepts record bytes and pushes their character class into the queue.
// ----------------------------------------------------------------------------
module vgfp_front (
    input  logic                 s_valid,
    output logic                 s_ready,
    input  vgfp_pkg::in_item_t   s_data,
    output logic                 push_valid,
    input  logic                 push_ready,
    output vgfp_pkg::byte_class_t push_data
);

    logic [7:0] b;

    assign b          = s_data.line_byte;
    assign s_ready    = push_ready;
    assign push_valid = s_valid;

    always_comb begin
        push_data          = '0;
        push_data.line_end = s_data.line_end;
        push_data.is_tab   = (b == vgfp_pkg::CHAR_TAB);
        push_data.is_g     = (b == vgfp_pkg::CHAR_G);
        push_data.is_t     = (b == vgfp_pkg::CHAR_T);
        push_data.is_dot   = (b == vgfp_pkg::CHAR_DOT);
        push_data.is_bar   = (b == vgfp_pkg::CHAR_BAR);
        push_data.is_slash = (b == vgfp_pkg::CHAR_SLASH);
        push_data.is_digit = (b >= vgfp_pkg::CHAR_ZERO) && (b <= vgfp_pkg::CHAR_NINE);
        // ASCII digits carry their value in the low nibble
        push_data.digit    = b[3:0];
    end

endmodule

// ===== hdl/vgfp_queue.sv =====
// ----------------------------------------------------------------------------
// vgfp_queue: classified byte queue
// Small register FIFO that decouples the classifier from the parser.
// ----------------------------------------------------------------------------
module vgfp_queue #(
    parameter int DEPTH = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  vgfp_pkg::byte_class_t push_data,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output vgfp_pkg::byte_class_t pop_data
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    vgfp_pkg::byte_class_t entry_reg [DEPTH];
    logic [IW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [IW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/vgfp_back.sv =====
// ----------------------------------------------------------------------------
// vgfp_back: genotype field parser and result register
// Finds the GT tag, splits sample fields at tabs, accumulates both alleles
// and drives one result per closed field.
// ----------------------------------------------------------------------------
module vgfp_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  vgfp_pkg::byte_class_t pop_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output vgfp_pkg::out_item_t   m_data
);

    vgfp_pkg::phase_t    phase_reg, phase_next;
    vgfp_pkg::tag_t      tag_reg, tag_next;
    logic [7:0]          first_reg, first_next;
    logic [7:0]          second_reg, second_next;
    logic                start_reg, start_next;
    logic                miss_reg, miss_next;
    logic                sep_reg, sep_next;
    logic                d1_reg, d1_next;
    logic                d2_reg, d2_next;
    logic                bar_reg, bar_next;
    logic                out_valid_reg, out_valid_next;
    vgfp_pkg::out_item_t out_data_reg, out_data_next;

    // Field state after absorbing the current byte
    logic       a_start, a_miss, a_sep, a_d1, a_d2, a_bar;
    logic [7:0] a_first, a_second;
    logic       pop;

    function automatic logic [7:0] mac10(input logic [7:0] v, input logic [3:0] d);
        mac10 = {v[4:0], 3'b000} + {v[6:0], 1'b0} + {4'b0000, d};
    endfunction

    function automatic vgfp_pkg::out_item_t make_result(
        input logic miss, input logic sep, input logic bar,
        input logic [7:0] first, input logic [7:0] second, input logic last);
        vgfp_pkg::out_item_t r;
        r.sample_last = last;
        if (miss) begin
            r.allele_first  = vgfp_pkg::ALLELE_MISSING;
            r.allele_second = vgfp_pkg::ALLELE_MISSING;
            r.phased        = 1'b0;
            r.missing       = 1'b1;
            r.no_separator  = 1'b0;
        end else if (!sep) begin
            r.allele_first  = first;
            r.allele_second = '0;
            r.phased        = 1'b0;
            r.missing       = 1'b0;
            r.no_separator  = 1'b1;
        end else begin
            r.allele_first  = first;
            r.allele_second = second;
            r.phased        = bar;
            r.missing       = 1'b0;
            r.no_separator  = 1'b0;
        end
        make_result = r;
    endfunction

    assign pop       = pop_valid && (!out_valid_reg || m_ready);
    assign pop_ready = !out_valid_reg || m_ready;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    always_comb begin
        a_start  = start_reg;
        a_miss   = miss_reg;
        a_sep    = sep_reg;
        a_d1     = d1_reg;
        a_d2     = d2_reg;
        a_bar    = bar_reg;
        a_first  = first_reg;
        a_second = second_reg;
        if (!miss_reg) begin
            if (start_reg) begin
                a_start = 1'b0;
                a_miss  = pop_data.is_dot;
            end
            if (!a_miss) begin
                if (!sep_reg) begin
                    if (pop_data.is_bar || pop_data.is_slash) begin
                        a_d1  = 1'b0;
                        a_sep = 1'b1;
                        a_d2  = 1'b1;
                        a_bar = bar_reg | pop_data.is_bar;
                    end else if (d1_reg) begin
                        if (pop_data.is_digit) begin
                            a_first = mac10(first_reg, pop_data.digit);
                        end else begin
                            a_d1 = 1'b0;
                        end
                    end
                end else if (d2_reg) begin
                    if (pop_data.is_digit) begin
                        a_second = mac10(second_reg, pop_data.digit);
                    end else begin
                        a_d2 = 1'b0;
                    end
                end
            end
        end
    end

    always_comb begin
        phase_next     = phase_reg;
        tag_next       = tag_reg;
        first_next     = first_reg;
        second_next    = second_reg;
        start_next     = start_reg;
        miss_next      = miss_reg;
        sep_next       = sep_reg;
        d1_next        = d1_reg;
        d2_next        = d2_reg;
        bar_next       = bar_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_ready;

        if (pop) begin
            case (phase_reg)
                vgfp_pkg::PH_SEARCH: begin
                    if (tag_reg == vgfp_pkg::TAG_GT && pop_data.is_tab) begin
                        tag_next = vgfp_pkg::TAG_NONE;
                        if (!pop_data.line_end) begin
                            phase_next  = vgfp_pkg::PH_FIELD;
                            first_next  = '0;
                            second_next = '0;
                            start_next  = 1'b1;
                            miss_next   = 1'b0;
                            sep_next    = 1'b0;
                            d1_next     = 1'b1;
                            d2_next     = 1'b0;
                            bar_next    = 1'b0;
                        end
                    end else if (pop_data.is_g) begin
                        tag_next = vgfp_pkg::TAG_G;
                    end else if (tag_reg == vgfp_pkg::TAG_G && pop_data.is_t) begin
                        tag_next = vgfp_pkg::TAG_GT;
                    end else begin
                        tag_next = vgfp_pkg::TAG_NONE;
                    end
                    if (pop_data.line_end) begin
                        tag_next = vgfp_pkg::TAG_NONE;
                    end
                end
                vgfp_pkg::PH_FIELD: begin
                    if (pop_data.is_tab) begin
                        // Close the field with its state before the tab
                        out_valid_next = 1'b1;
                        out_data_next  = make_result(miss_reg, sep_reg, bar_reg,
                                                     first_reg, second_reg,
                                                     pop_data.line_end);
                        if (pop_data.line_end) begin
                            phase_next = vgfp_pkg::PH_SEARCH;
                            tag_next   = vgfp_pkg::TAG_NONE;
                        end else begin
                            first_next  = '0;
                            second_next = '0;
                            start_next  = 1'b1;
                            miss_next   = 1'b0;
                            sep_next    = 1'b0;
                            d1_next     = 1'b1;
                            d2_next     = 1'b0;
                            bar_next    = 1'b0;
                        end
                    end else begin
                        first_next  = a_first;
                        second_next = a_second;
                        start_next  = a_start;
                        miss_next   = a_miss;
                        sep_next    = a_sep;
                        d1_next     = a_d1;
                        d2_next     = a_d2;
                        bar_next    = a_bar;
                        if (pop_data.line_end) begin
                            out_valid_next = 1'b1;
                            out_data_next  = make_result(a_miss, a_sep, a_bar,
                                                         a_first, a_second, 1'b1);
                            phase_next     = vgfp_pkg::PH_SEARCH;
                            tag_next       = vgfp_pkg::TAG_NONE;
                        end
                    end
                end
                default: begin
                    phase_next = vgfp_pkg::PH_SEARCH;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= vgfp_pkg::PH_SEARCH;
            tag_reg       <= vgfp_pkg::TAG_NONE;
            first_reg     <= '0;
            second_reg    <= '0;
            start_reg     <= 1'b0;
            miss_reg      <= 1'b0;
            sep_reg       <= 1'b0;
            d1_reg        <= 1'b0;
            d2_reg        <= 1'b0;
            bar_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            tag_reg       <= tag_next;
            first_reg     <= first_next;
            second_reg    <= second_next;
            start_reg     <= start_next;
            miss_reg      <= miss_next;
            sep_reg       <= sep_next;
            d1_reg        <= d1_next;
            d2_reg        <= d2_next;
            bar_reg       <= bar_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

endmodule

// ===== hdl/vcf_genotype_field_parser_top.sv =====
// ----------------------------------------------------------------------------
// vcf_genotype_field_parser_top: GT column parser for text variant records
// Streams one record byte per transfer and reports one genotype per sample.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one line byte per transfer, with line_end
//   set on the final byte of each record line. Bytes before the first
//   G, T, tab sequence are skipped; after it each tab-separated sample field
//   yields one transfer on m_valid/m_ready/m_data when the field closes.
//   Throughput: one byte per cycle sustained. The classifier takes a byte
//   every cycle while the queue has room; the parser retires one queued
//   byte per cycle while the result register is free or being drained.
//   A byte that closes a field is written into the queue, then the parser
//   steps it into the result register, which drives the result on m_data.
//   When the receiver stalls, the result register holds, the parser stops,
//   and s_ready drops once QUEUE_DEPTH bytes are queued.
//   Reset (aresetn low, synchronous) empties the queue, clears m_valid and
//   returns the parser to the tag search.
// ----------------------------------------------------------------------------
module vcf_genotype_field_parser_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  vgfp_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output vgfp_pkg::out_item_t m_data
);

    logic                  push_valid, push_ready;
    vgfp_pkg::byte_class_t push_data;
    logic                  pop_valid, pop_ready;
    vgfp_pkg::byte_class_t pop_data;

    vgfp_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    vgfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    vgfp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== hdl/vgfp_checker.sv =====
// ----------------------------------------------------------------------------
// vgfp_checker: port-level checks for the genotype field parser
// Watches the result channel and the consistency of result flags.
// ----------------------------------------------------------------------------
module vgfp_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input vgfp_pkg::out_item_t m_data
);

    // Hold a stalled result unchanged
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_missing_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.missing |->
            m_data.allele_first == vgfp_pkg::ALLELE_MISSING &&
            m_data.allele_second == vgfp_pkg::ALLELE_MISSING &&
            !m_data.phased && !m_data.no_separator)
        else $error("missing field result malformed");

    a_nosep_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.no_separator |->
            m_data.allele_second == 8'd0 && !m_data.phased && !m_data.missing)
        else $error("no-separator result malformed");

endmodule

bind vcf_genotype_field_parser_top vgfp_checker u_vgfp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== tb/sv/tb_vcf_genotype_field_parser_top.sv =====
// ----------------------------------------------------------------------------
// tb_vcf_genotype_field_parser_top: self-checking bench for the GT parser
// Streams record lines one byte per transfer: a short directed table, then
// randomly built lines (mostly well-formed GT columns, some noise and broken
// tags). A behavioral parser predicts each genotype result, and the result
// stream is compared field by field. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_vcf_genotype_field_parser_top;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_BYTES = 1350;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        vgfp_pkg::in_item_t  stim;
        bit                  typed;
        vgfp_pkg::out_item_t want;
    } table_row_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    vgfp_pkg::in_item_t  s_data;
    logic                m_valid;
    logic                m_ready = 1'b0;
    vgfp_pkg::out_item_t m_data;

    vcf_genotype_field_parser_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Behavioral parser state
    vgfp_pkg::phase_t cur_phase;
    vgfp_pkg::tag_t   cur_tag;
    logic [7:0]       cur_first;
    logic [7:0]       cur_second;
    bit               fl_start, fl_miss, fl_sep, fl_d1, fl_d2, fl_bar;

    vgfp_pkg::out_item_t genotype_q[$];
    table_row_t          directed_rows[$];
    vgfp_pkg::in_item_t  line_q[$];

    int mismatches = 0;
    int cycle_cnt  = 0;
    int n_results  = 0;
    int n_missing  = 0;
    int n_phased   = 0;
    int n_unphased = 0;
    int n_nosep    = 0;
    int n_lines    = 0;
    int n_gt_lines = 0;
    int n_bytes    = 0;
    int sink_hold  = 0;
    int sink_span  = 0;
    bit sink_calm  = 1'b0;
    vgfp_pkg::out_item_t oldest;

    function automatic vgfp_pkg::out_item_t mk_geno(logic [7:0] a1, logic [7:0] a2,
                                                    logic ph, logic miss,
                                                    logic nosep, logic last);
        vgfp_pkg::out_item_t r;
        r.allele_first  = a1;
        r.allele_second = a2;
        r.phased        = ph;
        r.missing       = miss;
        r.no_separator  = nosep;
        r.sample_last   = last;
        return r;
    endfunction

    function automatic void open_field();
        cur_first  = 8'd0;
        cur_second = 8'd0;
        fl_start   = 1'b1;
        fl_miss    = 1'b0;
        fl_sep     = 1'b0;
        fl_d1      = 1'b1;
        fl_d2      = 1'b0;
        fl_bar     = 1'b0;
    endfunction

    function automatic vgfp_pkg::out_item_t field_genotype(logic last);
        if (fl_miss)
            return mk_geno(vgfp_pkg::ALLELE_MISSING, vgfp_pkg::ALLELE_MISSING,
                           1'b0, 1'b1, 1'b0, last);
        if (!fl_sep)
            return mk_geno(cur_first, 8'd0, 1'b0, 1'b0, 1'b1, last);
        return mk_geno(cur_first, cur_second, fl_bar, 1'b0, 1'b0, last);
    endfunction

    function automatic void absorb_byte(logic [7:0] b);
        bit         is_num;
        logic [7:0] d;
        is_num = (b >= vgfp_pkg::CHAR_ZERO) && (b <= vgfp_pkg::CHAR_NINE);
        d      = b - vgfp_pkg::CHAR_ZERO;
        if (fl_miss)
            return;
        if (fl_start) begin
            fl_start = 1'b0;
            if (b == vgfp_pkg::CHAR_DOT) begin
                fl_miss = 1'b1;
                return;
            end
        end
        if (!fl_sep) begin
            if (b == vgfp_pkg::CHAR_BAR || b == vgfp_pkg::CHAR_SLASH) begin
                fl_d1  = 1'b0;
                fl_sep = 1'b1;
                fl_d2  = 1'b1;
                fl_bar = (b == vgfp_pkg::CHAR_BAR);
                return;
            end
            if (fl_d1) begin
                if (is_num)
                    cur_first = cur_first * 8'd10 + d;
                else
                    fl_d1 = 1'b0;
            end
            return;
        end
        if (fl_d2) begin
            if (is_num)
                cur_second = cur_second * 8'd10 + d;
            else
                fl_d2 = 1'b0;
        end
    endfunction

    // Advance the parser by one byte; return 1 when a field closes
    function automatic bit parse_byte(input vgfp_pkg::in_item_t it,
                                      output vgfp_pkg::out_item_t res);
        logic [7:0] b;
        bit         found;
        b     = it.line_byte;
        found = 1'b0;
        res   = '0;
        if (cur_phase != vgfp_pkg::PH_FIELD) begin
            if (cur_tag == vgfp_pkg::TAG_GT && b == vgfp_pkg::CHAR_TAB) begin
                found   = 1'b1;
                cur_tag = vgfp_pkg::TAG_NONE;
            end else if (b == vgfp_pkg::CHAR_G) begin
                cur_tag = vgfp_pkg::TAG_G;
            end else if (cur_tag == vgfp_pkg::TAG_G && b == vgfp_pkg::CHAR_T) begin
                cur_tag = vgfp_pkg::TAG_GT;
            end else begin
                cur_tag = vgfp_pkg::TAG_NONE;
            end
            if (it.line_end) begin
                cur_tag = vgfp_pkg::TAG_NONE;
            end else if (found) begin
                cur_phase = vgfp_pkg::PH_FIELD;
                open_field();
            end
            return 1'b0;
        end
        if (b == vgfp_pkg::CHAR_TAB) begin
            res = field_genotype(it.line_end);
            if (it.line_end) begin
                cur_phase = vgfp_pkg::PH_SEARCH;
                cur_tag   = vgfp_pkg::TAG_NONE;
            end else begin
                open_field();
            end
            return 1'b1;
        end
        absorb_byte(b);
        if (it.line_end) begin
            res       = field_genotype(1'b1);
            cur_phase = vgfp_pkg::PH_SEARCH;
            cur_tag   = vgfp_pkg::TAG_NONE;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] junk_char();
        case ($urandom_range(0, 7))
            0:       return vgfp_pkg::CHAR_DOT;
            1:       return vgfp_pkg::CHAR_BAR;
            2:       return vgfp_pkg::CHAR_SLASH;
            3:       return vgfp_pkg::CHAR_TAB;
            4, 5:    return vgfp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int allele_value();
        if ($urandom_range(0, 4) != 0)
            return $urandom_range(0, 3);
        return $urandom_range(0, 999);
    endfunction

    task automatic add_row(logic [7:0] b, logic last, bit typed = 1'b0,
                           vgfp_pkg::out_item_t want = '0);
        table_row_t row;
        row.stim.line_byte = b;
        row.stim.line_end  = last;
        row.typed          = typed;
        row.want           = want;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    task automatic push_char(logic [7:0] b);
        vgfp_pkg::in_item_t it;
        it.line_byte = b;
        it.line_end  = 1'b0;
        line_q.insert(line_q.size(), it);
    endtask

    task automatic push_num(int v);
        string s;
        s = $sformatf("%0d", v);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i]);
    endtask

    task automatic push_sample();
        case ($urandom_range(0, 9))
            0: begin
                push_char(vgfp_pkg::CHAR_DOT);
                if ($urandom_range(0, 1)) begin
                    push_char(vgfp_pkg::CHAR_SLASH);
                    push_char(vgfp_pkg::CHAR_DOT);
                end
            end
            1, 2, 3, 4, 5: begin
                push_num(allele_value());
                push_char($urandom_range(0, 1) ? vgfp_pkg::CHAR_BAR : vgfp_pkg::CHAR_SLASH);
                push_num(allele_value());
            end
            6: push_num(allele_value());
            7: ;
            8: begin
                push_num($urandom_range(0, 9999));
                push_char($urandom_range(0, 1) ? vgfp_pkg::CHAR_BAR : vgfp_pkg::CHAR_SLASH);
                push_num($urandom_range(0, 9999));
            end
            default: begin
                repeat ($urandom_range(1, 5)) push_char(junk_char());
            end
        endcase
        // Trailing FORMAT subfields such as ":35" follow the genotype
        if ($urandom_range(0, 3) == 0) begin
            push_char(8'h3A);
            push_num(allele_value());
        end
    endtask

    // Build one record line in line_q; flag well-formed GT lines
    task automatic build_line(output bit well_formed);
        int kind;
        line_q.delete();
        kind        = $urandom_range(0, 99);
        well_formed = (kind < 75);
        if (kind < 75) begin
            repeat ($urandom_range(0, 6)) push_char(8'($urandom_range(32, 126)));
            push_char(vgfp_pkg::CHAR_G);
            push_char(vgfp_pkg::CHAR_T);
            push_char(vgfp_pkg::CHAR_TAB);
            for (int i = 0; i < $urandom_range(1, 6); i++) begin
                if (i > 0)
                    push_char(vgfp_pkg::CHAR_TAB);
                push_sample();
            end
            if ($urandom_range(0, 7) == 0)
                push_char(vgfp_pkg::CHAR_TAB);
        end else if (kind < 90) begin
            repeat ($urandom_range(1, 16)) begin
                case ($urandom_range(0, 3))
                    0:       push_char(vgfp_pkg::CHAR_G);
                    1:       push_char(vgfp_pkg::CHAR_T);
                    default: push_char(junk_char());
                endcase
            end
        end else begin
            push_char(vgfp_pkg::CHAR_G);
            case ($urandom_range(0, 3))
                0: begin
                    push_char(8'h78);
                    push_char(vgfp_pkg::CHAR_T);
                    push_char(vgfp_pkg::CHAR_TAB);
                end
                1: begin
                    push_char(vgfp_pkg::CHAR_G);
                    push_char(vgfp_pkg::CHAR_T);
                    push_char(vgfp_pkg::CHAR_TAB);
                end
                2: push_char(vgfp_pkg::CHAR_T);
                default: begin
                    push_char(vgfp_pkg::CHAR_TAB);
                    push_char(vgfp_pkg::CHAR_T);
                    push_char(vgfp_pkg::CHAR_TAB);
                end
            endcase
            repeat ($urandom_range(0, 4)) push_char(junk_char());
        end
        line_q[line_q.size() - 1].line_end = 1'b1;
    endtask

    // Present one byte, record its expected genotype, hold until transfer
    task automatic drive_byte(vgfp_pkg::in_item_t it, bit typed,
                              vgfp_pkg::out_item_t want, bit calm);
        vgfp_pkg::out_item_t res;
        int                  gap;
        gap = calm ? 0 : pick_gap();
        repeat (gap) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        if (parse_byte(it, res))
            genotype_q.insert(genotype_q.size(), typed ? want : res);
        do @(posedge aclk); while (!s_ready);
        n_bytes++;
    endtask

    task automatic check_field(string name, int unsigned want_v, int unsigned got_v);
        if (want_v != got_v) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    // Receiver: random stalls, with calm stretches
    always @(posedge aclk) begin
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (!sink_calm && $urandom_range(0, 3) == 0)
                sink_hold <= pick_gap();
        end
        if (sink_span == 0) begin
            sink_calm <= ($urandom_range(0, 3) == 0);
            sink_span <= $urandom_range(20, 300);
        end else begin
            sink_span <= sink_span - 1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (m_data.missing)           n_missing++;
            else if (m_data.no_separator) n_nosep++;
            else if (m_data.phased)       n_phased++;
            else                          n_unphased++;
            if (genotype_q.size() == 0) begin
                $display("%0t: unexpected genotype, expected none, got %p", $time, m_data);
                mismatches++;
            end else begin
                oldest = genotype_q.pop_front();
                check_field("allele_first",  oldest.allele_first,  m_data.allele_first);
                check_field("allele_second", oldest.allele_second, m_data.allele_second);
                check_field("phased",        oldest.phased,        m_data.phased);
                check_field("missing",       oldest.missing,       m_data.missing);
                check_field("no_separator",  oldest.no_separator,  m_data.no_separator);
                check_field("sample_last",   oldest.sample_last,   m_data.sample_last);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d genotypes outstanding",
                     cycle_cnt, genotype_q.size());
            $display("vcf_genotype_field_parser_top: mismatch");
            $finish;
        end
    end

    initial begin
        bit well_formed;
        bit calm;
        int random_bytes;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;

        cur_phase = vgfp_pkg::PH_SEARCH;
        cur_tag   = vgfp_pkg::TAG_NONE;
        cur_first  = 8'd0;
        cur_second = 8'd0;
        {fl_start, fl_miss, fl_sep, fl_d1, fl_d2, fl_bar} = '0;

        // Missing field, then slash genotype closed by a trailing tab
        add_row(vgfp_pkg::CHAR_G, 1'b0);
        add_row(vgfp_pkg::CHAR_T, 1'b0);
        add_row(vgfp_pkg::CHAR_TAB, 1'b0);
        add_row(vgfp_pkg::CHAR_DOT, 1'b0);
        add_row(vgfp_pkg::CHAR_TAB, 1'b0, 1'b1,
                mk_geno(8'hFF, 8'hFF, 1'b0, 1'b1, 1'b0, 1'b0));
        add_row(vgfp_pkg::CHAR_ZERO, 1'b0);
        add_row(vgfp_pkg::CHAR_SLASH, 1'b0);
        add_row(vgfp_pkg::CHAR_ZERO, 1'b0);
        add_row(vgfp_pkg::CHAR_TAB, 1'b1, 1'b1,
                mk_geno(8'd0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b1));
        // Tag whose tab ends the line
        add_row(vgfp_pkg::CHAR_G, 1'b0);
        add_row(vgfp_pkg::CHAR_T, 1'b0);
        add_row(vgfp_pkg::CHAR_TAB, 1'b1);
        // Non-digit field, empty field, overflowing bar genotype with junk
        add_row(vgfp_pkg::CHAR_G, 1'b0);
        add_row(vgfp_pkg::CHAR_T, 1'b0);
        add_row(vgfp_pkg::CHAR_TAB, 1'b0);
        add_row(8'hFF, 1'b0);
        add_row(vgfp_pkg::CHAR_TAB, 1'b0, 1'b1,
                mk_geno(8'd0, 8'd0, 1'b0, 1'b0, 1'b1, 1'b0));
        add_row(vgfp_pkg::CHAR_TAB, 1'b0, 1'b1,
                mk_geno(8'd0, 8'd0, 1'b0, 1'b0, 1'b1, 1'b0));
        add_row(vgfp_pkg::CHAR_ZERO + 8'd3, 1'b0);
        add_row(vgfp_pkg::CHAR_ZERO, 1'b0);
        add_row(vgfp_pkg::CHAR_ZERO, 1'b0);
        add_row(vgfp_pkg::CHAR_BAR, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(vgfp_pkg::CHAR_ZERO + 8'd1, 1'b1);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            drive_byte(directed_rows[i].stim, directed_rows[i].typed,
                       directed_rows[i].want, 1'b0);
        n_lines = 3;

        random_bytes = 0;
        while (random_bytes < RANDOM_BYTES) begin
            build_line(well_formed);
            calm = ($urandom_range(0, 3) == 0);
            foreach (line_q[i])
                drive_byte(line_q[i], 1'b0, '0, calm);
            random_bytes += line_q.size();
            if (well_formed)
                n_gt_lines++;
            n_lines++;
        end
        s_valid <= 1'b0;

        while (genotype_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d bytes in %0d record lines (%0d random GT lines), checked %0d genotypes",
                 n_bytes, n_lines, n_gt_lines, n_results);
        $display("missing %0d, phased %0d, unphased %0d, no separator %0d",
                 n_missing, n_phased, n_unphased, n_nosep);
        if (mismatches == 0)
            $display("vcf_genotype_field_parser_top: match");
        else
            $display("vcf_genotype_field_parser_top: mismatch");
        $finish;
    end

endmodule
